// ===== hdl/sfd_pkg.sv =====
// Shared types and event codes for the sync/length frame deframer.
package sfd_pkg;

    // Event codes carried in event_kind
    localparam logic [1:0] EV_PAYLOAD  = 2'd0;
    localparam logic [1:0] EV_COMPLETE = 2'd1;
    localparam logic [1:0] EV_BAD_LEN  = 2'd2;

    // Sync byte that opens every frame
    localparam logic [7:0] SYNC_BYTE = 8'h00;

    // One result item
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last_payload;
        logic [15:0] frame_length;
        logic [15:0] received_crc;
    } sfd_result_t;

    // Result plus its valid flag, from parser to output stage
    typedef struct packed {
        logic        valid;
        sfd_result_t data;
    } sfd_result_bus_t;

endpackage

// ===== hdl/sync_length_frame_deframer_unit.sv =====
// Top level of the sync/length/inverted-length frame deframer.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_valid / s_ready  | s_rx_byte
//  m_      | out       | m_valid / m_ready  | m_event_kind, m_payload_byte,
//          |           |                    | m_byte_index, m_last_payload,
//          |           |                    | m_frame_length, m_received_crc
//
// One byte is accepted per cycle while s_ready is high; the byte passes through the input
// register and the parser logic, and any result it yields is held in the result register.
// Synchronous active-low reset returns the parser to sync hunting and empties both registers.
// A waiting result stalls the parser: the input register takes at most one more byte,
// then s_ready stays low until m_ready frees the result register.
module sync_length_frame_deframer_unit #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_byte_index,
    output logic        m_last_payload,
    output logic [15:0] m_frame_length,
    output logic [15:0] m_received_crc
);

    logic                     advance;
    logic                     in_valid;
    logic [7:0]               in_byte;
    sfd_pkg::sfd_result_bus_t result;
    sfd_pkg::sfd_result_t     m_data;

    sfd_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    sfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_valid && advance),
        .in_byte (in_byte),
        .result  (result)
    );

    sfd_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .result  (result),
        .advance (advance),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Spread the result onto its ports
    assign m_event_kind   = m_data.event_kind;
    assign m_payload_byte = m_data.payload_byte;
    assign m_byte_index   = m_data.byte_index;
    assign m_last_payload = m_data.last_payload;
    assign m_frame_length = m_data.frame_length;
    assign m_received_crc = m_data.received_crc;

endmodule

// ===== hdl/sfd_in_stage.sv =====
// Input register stage: holds one received byte until the parser consumes it.
module sfd_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Take a new item when empty or when the held one moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ===== hdl/sfd_parser.sv =====
// Frame parser: sync hunt, header check, payload indexing and CRC capture.
module sfd_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    output sfd_pkg::sfd_result_bus_t result
);

    localparam logic [2:0] ST_HUNT   = 3'd0;
    localparam logic [2:0] ST_LEN_LO = 3'd1;
    localparam logic [2:0] ST_LEN_HI = 3'd2;
    localparam logic [2:0] ST_CHK_LO = 3'd3;
    localparam logic [2:0] ST_CHK_HI = 3'd4;
    localparam logic [2:0] ST_DATA   = 3'd5;

    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 1);
    localparam logic [LENGTH_BITS-1:0] COUNT_ONE = LENGTH_BITS'(1);

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [15:0]            len_reg;
    logic [15:0]            len_next;
    logic [7:0]             chk_low_reg;
    logic [7:0]             chk_low_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic                   crc_have_reg;
    logic                   crc_have_next;
    logic [7:0]             crc_low_reg;
    logic [7:0]             crc_low_next;

    logic [15:0]            check_word;
    logic                   header_ok;
    logic [15:0]            count_ext;
    logic [15:0]            count_inc;

    assign check_word = {in_byte, chk_low_reg};
    assign header_ok  = (len_reg == ~check_word) && ((len_reg & ~LEN_MASK) == 16'h0000);
    assign count_ext  = 16'(count_reg);
    assign count_inc  = 16'(count_ext + 16'd1);

    // Decode one byte and pick the next state and result
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        chk_low_next  = chk_low_reg;
        count_next    = count_reg;
        crc_have_next = crc_have_reg;
        crc_low_next  = crc_low_reg;
        result        = '0;
        if (step) begin
            case (state_reg)
                ST_HUNT: begin
                    if (in_byte == sfd_pkg::SYNC_BYTE) begin
                        state_next = ST_LEN_LO;
                    end
                end
                ST_LEN_LO: begin
                    len_next   = {8'h00, in_byte};
                    state_next = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    len_next   = {in_byte, len_reg[7:0]};
                    state_next = ST_CHK_LO;
                end
                ST_CHK_LO: begin
                    chk_low_next = in_byte;
                    state_next   = ST_CHK_HI;
                end
                ST_CHK_HI: begin
                    if (header_ok) begin
                        state_next = ST_DATA;
                    end else begin
                        result.valid             = 1'b1;
                        result.data.event_kind   = sfd_pkg::EV_BAD_LEN;
                        result.data.frame_length = len_reg;
                        state_next               = ST_HUNT;
                        count_next               = '0;
                        crc_have_next            = 1'b0;
                    end
                end
                ST_DATA: begin
                    if (count_ext < len_reg) begin
                        // Pass a payload byte with its index
                        result.valid             = 1'b1;
                        result.data.event_kind   = sfd_pkg::EV_PAYLOAD;
                        result.data.payload_byte = in_byte;
                        result.data.byte_index   = count_ext;
                        result.data.last_payload = (count_inc == len_reg);
                        result.data.frame_length = len_reg;
                        count_next               = count_reg + COUNT_ONE;
                    end else if (!crc_have_reg) begin
                        crc_low_next  = in_byte;
                        crc_have_next = 1'b1;
                    end else begin
                        // Close the frame with the received CRC
                        result.valid             = 1'b1;
                        result.data.event_kind   = sfd_pkg::EV_COMPLETE;
                        result.data.frame_length = len_reg;
                        result.data.received_crc = {in_byte, crc_low_reg};
                        state_next               = ST_HUNT;
                        count_next               = '0;
                        crc_have_next            = 1'b0;
                    end
                end
                default: begin
                    state_next    = ST_HUNT;
                    count_next    = '0;
                    crc_have_next = 1'b0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HUNT;
            count_reg    <= '0;
            crc_have_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            crc_have_reg <= crc_have_next;
        end
    end

    // Header and CRC byte holders
    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        chk_low_reg <= chk_low_next;
        crc_low_reg <= crc_low_next;
    end

    // Payload index always lies inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.data.event_kind == sfd_pkg::EV_PAYLOAD)
        |-> (result.data.byte_index < result.data.frame_length))
        else $error("payload index beyond frame length");

    // Last flag marks exactly the final payload byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && result.data.last_payload)
        |-> (16'(result.data.byte_index + 16'd1) == result.data.frame_length))
        else $error("last flag on wrong payload byte");

    // A bad header or a finished frame sends the parser back to hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result.valid && (result.data.event_kind == sfd_pkg::EV_BAD_LEN ||
                          result.data.event_kind == sfd_pkg::EV_COMPLETE))
        |=> (state_reg == ST_HUNT && count_reg == '0 && !crc_have_reg))
        else $error("parser not back in hunt after frame end");

    // Payload count never runs past the accepted length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA) |-> (count_ext <= len_reg))
        else $error("payload count past frame length");

endmodule

// ===== hdl/sfd_out_stage.sv =====
// Output register stage: holds one result item until the consumer takes it.
module sfd_out_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sfd_pkg::sfd_result_bus_t result,
    output logic                     advance,
    output logic                     m_valid,
    input  logic                     m_ready,
    output sfd_pkg::sfd_result_t     m_data
);

    logic                 valid_reg;
    logic                 valid_next;
    sfd_pkg::sfd_result_t data_reg;

    // Move on when empty or when the held item is taken
    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result
    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            data_reg <= result.data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== test/sfd_checker.sv =====
// Deframer checker: watches both channels, predicts each result and compares it.
module sfd_checker #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_event_kind,
    input  logic [7:0]  m_payload_byte,
    input  logic [15:0] m_byte_index,
    input  logic        m_last_payload,
    input  logic [15:0] m_frame_length,
    input  logic [15:0] m_received_crc,
    output int          mismatches,
    output int          pending,
    output int          payload_seen,
    output int          complete_seen,
    output int          bad_len_seen
);

    // Header positions of the parser
    localparam logic [2:0] POS_HUNT   = 3'd0;
    localparam logic [2:0] POS_LEN_LO = 3'd1;
    localparam logic [2:0] POS_LEN_HI = 3'd2;
    localparam logic [2:0] POS_CHK_LO = 3'd3;
    localparam logic [2:0] POS_CHK_HI = 3'd4;
    localparam logic [2:0] POS_BODY   = 3'd5;

    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

    // Mirror of the parser state
    logic        in_frame;
    logic [2:0]  hdr_pos;
    logic [15:0] len_word;
    logic [7:0]  chk_lo;
    logic [15:0] body_count;
    logic [1:0]  crc_count;
    logic [7:0]  crc_lo;

    sfd_pkg::sfd_result_t expected_events[$];

    initial begin
        mismatches    = 0;
        payload_seen  = 0;
        complete_seen = 0;
        bad_len_seen  = 0;
        pending       = 0;
    end

    // Return the parser mirror to sync hunting
    task automatic clear_parser();
        in_frame   = 1'b0;
        hdr_pos    = POS_HUNT;
        len_word   = '0;
        chk_lo     = '0;
        body_count = '0;
        crc_count  = '0;
        crc_lo     = '0;
    endtask

    // Advance the mirror by one byte and queue the event it causes, if any
    task automatic deframe_byte(input logic [7:0] b);
        sfd_pkg::sfd_result_t ev;
        logic [15:0] chk;
        ev = '0;
        if (!in_frame) begin
            // Drop anything but the sync byte
            if (b == sfd_pkg::SYNC_BYTE) begin
                in_frame = 1'b1;
                hdr_pos  = POS_LEN_LO;
            end
            return;
        end
        case (hdr_pos)
            POS_LEN_LO: begin
                len_word = {8'h00, b};
                hdr_pos  = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                len_word[15:8] = b;
                hdr_pos        = POS_CHK_LO;
            end
            POS_CHK_LO: begin
                chk_lo  = b;
                hdr_pos = POS_CHK_HI;
            end
            POS_CHK_HI: begin
                chk = {b, chk_lo};
                if (len_word != ~chk || (len_word & ~LEN_MASK) != 16'h0000) begin
                    ev.event_kind   = sfd_pkg::EV_BAD_LEN;
                    ev.frame_length = len_word;
                    expected_events.push_back(ev);
                    clear_parser();
                end else begin
                    hdr_pos = POS_BODY;
                end
            end
            default: begin
                if (body_count < len_word) begin
                    ev.event_kind   = sfd_pkg::EV_PAYLOAD;
                    ev.payload_byte = b;
                    ev.byte_index   = body_count;
                    ev.last_payload = ({1'b0, body_count} + 17'd1 == {1'b0, len_word});
                    ev.frame_length = len_word;
                    expected_events.push_back(ev);
                    body_count = body_count + 16'd1;
                end else if (crc_count == 2'd0) begin
                    crc_lo    = b;
                    crc_count = 2'd1;
                end else begin
                    ev.event_kind   = sfd_pkg::EV_COMPLETE;
                    ev.frame_length = len_word;
                    ev.received_crc = {b, crc_lo};
                    expected_events.push_back(ev);
                    clear_parser();
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare the result first: it always belongs to an older byte
    always @(posedge aclk) begin
        sfd_pkg::sfd_result_t want;
        if (!aresetn) begin
            clear_parser();
            expected_events.delete();
        end else begin
            if (m_valid && m_ready) begin
                case (m_event_kind)
                    sfd_pkg::EV_PAYLOAD:  payload_seen++;
                    sfd_pkg::EV_COMPLETE: complete_seen++;
                    sfd_pkg::EV_BAD_LEN:  bad_len_seen++;
                    default: ;
                endcase
                if (expected_events.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, expected none, actual kind %0d",
                             $time, m_event_kind);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind",   want.event_kind,   m_event_kind);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("byte_index",   want.byte_index,   m_byte_index);
                    check_field("last_payload", want.last_payload, m_last_payload);
                    check_field("frame_length", want.frame_length, m_frame_length);
                    check_field("received_crc", want.received_crc, m_received_crc);
                end
            end
            if (s_valid && s_ready)
                deframe_byte(s_rx_byte);
        end
        pending <= expected_events.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the deframer: clock, reset, byte stimulus, receiver stalls, verdict.
module tb_top;

    localparam int LEN_BITS     = 16;
    localparam int ITEM_TARGET  = 1250;
    localparam int CALM_FROM    = 1100;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LEN_BITS) - 32'd1);

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_event_kind;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_byte_index;
    logic        m_last_payload;
    logic [15:0] m_frame_length;
    logic [15:0] m_received_crc;

    int mismatches;
    int pending;
    int payload_seen;
    int complete_seen;
    int bad_len_seen;

    int bytes_sent;
    int frames_tried;
    int idle_cycles;
    bit calm;
    bit hold_req;

    sync_length_frame_deframer_unit #(
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_payload_byte(m_payload_byte),
        .m_byte_index  (m_byte_index),
        .m_last_payload(m_last_payload),
        .m_frame_length(m_frame_length),
        .m_received_crc(m_received_crc)
    );

    sfd_checker #(
        .LENGTH_BITS(LEN_BITS)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_kind  (m_event_kind),
        .m_payload_byte(m_payload_byte),
        .m_byte_index  (m_byte_index),
        .m_last_payload(m_last_payload),
        .m_frame_length(m_frame_length),
        .m_received_crc(m_received_crc),
        .mismatches    (mismatches),
        .pending       (pending),
        .payload_seen  (payload_seen),
        .complete_seen (complete_seen),
        .bad_len_seen  (bad_len_seen)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold on request, none at the end
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one byte, with an optional idle burst first, and wait for its acceptance
    task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (counted)
            bytes_sent++;
    endtask

    // Sync, header, and for a good header the payload and CRC
    task automatic send_frame(input logic [15:0] len, input logic [15:0] chk,
                              input logic [15:0] crc);
        frames_tried++;
        send_byte(sfd_pkg::SYNC_BYTE);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(chk[7:0]);
        send_byte(chk[15:8]);
        if (chk == ~len && (len & ~LEN_MASK) == 16'h0000) begin
            for (int i = 0; i < int'(len); i++)
                send_byte(8'($urandom));
            send_byte(crc[7:0]);
            send_byte(crc[15:8]);
        end
    endtask

    // Hold the sender until every expected result has come out
    task automatic wait_drained();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        logic [7:0]  directed[$];
        logic [15:0] len;
        logic [15:0] chk;
        int          pick;

        s_valid     <= 1'b0;
        s_rx_byte   <= 8'h00;
        aresetn     <= 1'b0;
        bytes_sent   = 0;
        frames_tried = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: hunting noise, zero length, one-byte payload, bad checks
        directed = '{8'hFF, 8'h01,
                     8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h01, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        foreach (directed[i])
            send_byte(directed[i], i >= 2);
        s_valid <= 1'b0;
        wait_drained();

        // Random: mostly good frames, some bad headers and hunting noise
        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= CALM_FROM)
                calm = 1'b1;
            if (frames_tried == 6) begin
                // Long receiver hold while a frame keeps coming
                hold_req = 1'b1;
                len = 16'd40;
                send_frame(len, ~len, 16'($urandom));
                continue;
            end
            if (frames_tried == 20) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = 16'($urandom_range(0, 16));
                else if (pick < 95)
                    len = 16'($urandom_range(17, 64));
                else
                    len = 16'($urandom_range(100, 300));
                send_frame(len, ~len, 16'($urandom));
            end else if (pick < 85) begin
                // Single bit error in the check word
                len = 16'($urandom);
                chk = ~len ^ (16'h0001 << $urandom_range(0, 15));
                send_frame(len, chk, 16'h0000);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom_range(1, 255)), 1'b0);
            end else begin
                // Sync followed by a random header that must fail
                len = 16'($urandom);
                chk = 16'($urandom);
                if (chk == ~len)
                    chk = chk ^ 16'h0001;
                send_frame(len, chk, 16'h0000);
            end
        end
        s_valid <= 1'b0;

        // Drain and let the pipeline settle
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d frame bytes over %0d frames; saw %0d payload bytes,",
                 bytes_sent, frames_tried, payload_seen);
        $display("%0d completed frames and %0d rejected headers", complete_seen, bad_len_seen);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
